// ----- sv/assert_macros.svh -----
// Assertion macros shared by the RTL files.
// Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("assert failed");
`define ASSERT_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error("assert failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif
`endif

// ----- sv/gtg_pkg.sv -----
// Package for the go-to-goal steering controller: payload types, FSM states,
// register indexes and the CORDIC arctangent table. No dependencies.
`default_nettype none
package gtg_pkg;

  typedef struct packed {
    logic signed [23:0] pose_x;
    logic signed [23:0] pose_y;
    logic [15:0]        pose_heading;
  } pose_t;

  typedef struct packed {
    logic [15:0] left_duty;
    logic [15:0] right_duty;
    logic [15:0] bearing_to_goal;
    logic        goal_reached;
  } duty_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_CORDIC, ST_ERR, ST_MULP, ST_MULI, ST_SUM, ST_LEFT, ST_RIGHT,
    ST_OUT
  } state_e;

  localparam logic [2:0] REG_GOAL_X = 3'd0;
  localparam logic [2:0] REG_GOAL_Y = 3'd1;
  localparam logic [2:0] REG_KP     = 3'd2;
  localparam logic [2:0] REG_KI     = 3'd3;
  localparam logic [2:0] REG_SPEED  = 3'd4;
  localparam logic [2:0] REG_DMAX   = 3'd5;
  localparam logic [2:0] REG_TOL    = 3'd6;

  localparam int TableLen = 24;
  localparam logic [31:0] ATAN_TAB [TableLen] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087, 32'd667544,
    32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861, 32'd10430, 32'd5215,
    32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  localparam logic signed [18:0] PI_Q16 = 19'sd205887;

  // Duty is floor(num / 57344) = floor((num >> 13) / 7). Quotients of
  // 65536 and up always clamp, so only (num >> 13) below 7*65536 is divided,
  // by multiplying with ceil(2^22 / 7) and shifting by 22 (exact there).
  localparam logic [32:0] DUTY_SAT_LIMIT = 33'd458752;
  localparam logic [19:0] RECIP7_Q22     = 20'd599187;

endpackage
`default_nettype wire

// ----- sv/go_to_goal_pi_steering_top.sv -----
// Top level of the go-to-goal PI steering controller: APB registers,
// sequencer with a shared CORDIC shift/add datapath and a shared multiplier.
// Depends on gtg_pkg and assert_macros.svh.
//
// One pose transaction runs from acceptance through PREP, then the CORDIC
// rotations, which run one per cycle through a single shift/add unit; the
// error scaling and the P and I products then share one multiplier one per
// cycle, followed by SUM and the LEFT and RIGHT wheel duty states. The block
// takes no new pose until its result has been taken. Register writes are
// meant to apply to the next pose: the user must write only between poses,
// as the block itself does not enforce this.
`default_nettype none
`include "assert_macros.svh"
module go_to_goal_pi_steering_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire gtg_pkg::pose_t in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output gtg_pkg::duty_t    out_data_o,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  localparam int NSteps = (CORDIC_STEPS > gtg_pkg::TableLen) ? gtg_pkg::TableLen
                                                              : CORDIC_STEPS;
  localparam int CntW = $clog2(gtg_pkg::TableLen);

  // Configuration registers
  logic signed [23:0] goal_x_q, goal_y_q;
  logic [15:0] kp_q, ki_q, speed_q, dmax_q, tol_q;
  logic        wr_en;
  logic [2:0]  widx;
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign widx   = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q <= '0; goal_y_q <= '0; kp_q <= 16'd630; ki_q <= 16'd563;
      speed_q <= '0; dmax_q <= 16'hFFFF; tol_q <= 16'd3277;
    end else if (wr_en && paddr[1:0] == 2'b00) begin
      case (widx)
        gtg_pkg::REG_GOAL_X: goal_x_q <= pwdata[23:0];
        gtg_pkg::REG_GOAL_Y: goal_y_q <= pwdata[23:0];
        gtg_pkg::REG_KP:     kp_q <= pwdata[15:0];
        gtg_pkg::REG_KI:     ki_q <= pwdata[15:0];
        gtg_pkg::REG_SPEED:  speed_q <= pwdata[15:0];
        gtg_pkg::REG_DMAX:   dmax_q <= pwdata[15:0];
        gtg_pkg::REG_TOL:    tol_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      case (widx)
        gtg_pkg::REG_GOAL_X: prdata = {{8{goal_x_q[23]}}, goal_x_q};
        gtg_pkg::REG_GOAL_Y: prdata = {{8{goal_y_q[23]}}, goal_y_q};
        gtg_pkg::REG_KP:     prdata = {16'd0, kp_q};
        gtg_pkg::REG_KI:     prdata = {16'd0, ki_q};
        gtg_pkg::REG_SPEED:  prdata = {16'd0, speed_q};
        gtg_pkg::REG_DMAX:   prdata = {16'd0, dmax_q};
        gtg_pkg::REG_TOL:    prdata = {16'd0, tol_q};
        default:             prdata = '0;
      endcase
    end
  end

  // Sequencer state
  gtg_pkg::state_e state_q, state_d;
  logic [CntW-1:0] cnt_q;
  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      gtg_pkg::ST_IDLE:   if (in_valid_i) state_d = gtg_pkg::ST_PREP;
      gtg_pkg::ST_PREP:   state_d = gtg_pkg::ST_CORDIC;
      gtg_pkg::ST_CORDIC: if (cnt_q == CntW'(NSteps - 1)) state_d = gtg_pkg::ST_ERR;
      gtg_pkg::ST_ERR:    state_d = gtg_pkg::ST_MULP;
      gtg_pkg::ST_MULP:   state_d = gtg_pkg::ST_MULI;
      gtg_pkg::ST_MULI:   state_d = gtg_pkg::ST_SUM;
      gtg_pkg::ST_SUM:    state_d = gtg_pkg::ST_LEFT;
      gtg_pkg::ST_LEFT:   state_d = gtg_pkg::ST_RIGHT;
      gtg_pkg::ST_RIGHT:  state_d = gtg_pkg::ST_OUT;
      gtg_pkg::ST_OUT:    if (out_ready_i) state_d = gtg_pkg::ST_IDLE;
      default:            state_d = gtg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == gtg_pkg::ST_IDLE);
    out_valid_o = (state_q == gtg_pkg::ST_OUT);
  end

  // Datapath registers
  logic signed [25:0] dx_q, dy_q;       // goal minus pose, 25 bits needed
  logic signed [27:0] cx_q, cy_q;       // CORDIC vector, growth headroom
  logic [31:0]        z_q;
  logic [15:0]        hd_q, bear_q;
  logic               reached_q;
  logic signed [17:0] err13_q;
  logic signed [31:0] sum_q;
  logic signed [34:0] pterm_q;
  logic signed [40:0] iterm_q;
  logic signed [40:0] w13_q;
  logic signed [45:0] num_q;
  logic [15:0]        left_q, right_q;

  // Heading error as signed binary angle; goal at pose gives bearing 0
  logic signed [15:0] e_w;
  logic [15:0] bear_w;
  assign bear_w = (dx_q == '0 && dy_q == '0) ? 16'd0
                                              : 16'((33'(z_q) + 33'(1 << 15)) >> 16);
  assign e_w = signed'(bear_w - hd_q);

  // Saturating integral update
  logic signed [32:0] sum_raw;
  logic signed [31:0] sum_d_sat;
  always_comb begin
    sum_raw = 33'(sum_q) + 33'(err13_q);
    if (sum_raw > 33'sd2147483647)       sum_d_sat = 32'sh7FFFFFFF;
    else if (sum_raw < -33'sd2147483648) sum_d_sat = 32'sh80000000;
    else                                 sum_d_sat = sum_raw[31:0];
  end

  // Shared multiplier: 33x19 signed operands
  logic signed [32:0] mul_a;
  logic signed [18:0] mul_b;
  logic signed [51:0] mul_p;
  always_comb begin
    mul_a = '0; mul_b = '0;
    case (state_q)
      gtg_pkg::ST_ERR:  begin mul_a = 33'(e_w); mul_b = gtg_pkg::PI_Q16; end
      gtg_pkg::ST_MULP: begin mul_a = 33'(err13_q); mul_b = 19'(signed'({1'b0, kp_q})); end
      gtg_pkg::ST_MULI: begin mul_a = 33'(sum_d_sat); mul_b = 19'(signed'({1'b0, ki_q})); end
      default: ;
    endcase
    mul_p = 52'(mul_a) * 52'(mul_b);
  end

  // Duty from numerator: divide by 57344 through shift and reciprocal, clamp
  function automatic logic [15:0] duty_of(input logic signed [45:0] n,
                                          input logic [15:0] dmax);
    logic [32:0] m;
    logic [38:0] prod;
    logic [16:0] q;
    begin
      if (n < 0) return 16'd0;
      m = 33'(n >>> 13);
      if (m >= gtg_pkg::DUTY_SAT_LIMIT) return dmax;
      prod = 39'(m[18:0]) * 39'(gtg_pkg::RECIP7_Q22);
      q = 17'(prod >> 22);
      return (q > 17'(dmax)) ? dmax : q[15:0];
    end
  endfunction

  logic signed [45:0] base_w, w14_w;
  assign base_w = 46'(speed_q) <<< 13;
  assign w14_w  = (46'(w13_q) <<< 4) - (46'(w13_q) <<< 1);

  logic signed [27:0] xs, ys;
  assign xs = cx_q >>> cnt_q;
  assign ys = cy_q >>> cnt_q;
  logic [25:0] adx, ady;
  assign adx = dx_q[25] ? 26'(-dx_q) : 26'(dx_q);
  assign ady = dy_q[25] ? 26'(-dy_q) : 26'(dy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gtg_pkg::ST_IDLE;
      cnt_q   <= '0;
      sum_q   <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        gtg_pkg::ST_CORDIC: cnt_q <= cnt_q + 1'b1;
        gtg_pkg::ST_MULI:   sum_q <= sum_d_sat;
        default:            cnt_q <= '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      gtg_pkg::ST_IDLE: if (in_acc) begin
        dx_q <= 26'(goal_x_q) - 26'(in_data_i.pose_x);
        dy_q <= 26'(goal_y_q) - 26'(in_data_i.pose_y);
        hd_q <= in_data_i.pose_heading;
      end
      gtg_pkg::ST_PREP: begin
        reached_q <= (adx < 26'(tol_q)) && (ady < 26'(tol_q));
        if (dx_q[25]) begin
          if (!dy_q[25]) begin
            cx_q <= 28'(dy_q); cy_q <= -28'(dx_q); z_q <= 32'h40000000;
          end else begin
            cx_q <= -28'(dy_q); cy_q <= 28'(dx_q); z_q <= 32'hC0000000;
          end
        end else begin
          cx_q <= 28'(dx_q); cy_q <= 28'(dy_q); z_q <= '0;
        end
      end
      gtg_pkg::ST_CORDIC: begin
        if (cy_q > 0) begin
          cx_q <= cx_q + ys; cy_q <= cy_q - xs;
          z_q <= z_q + gtg_pkg::ATAN_TAB[cnt_q[4:0]];
        end else begin
          cx_q <= cx_q - ys; cy_q <= cy_q + xs;
          z_q <= z_q - gtg_pkg::ATAN_TAB[cnt_q[4:0]];
        end
      end
      gtg_pkg::ST_ERR: begin
        bear_q  <= bear_w;
        err13_q <= 18'((mul_p + 52'sd131072) >>> 18);
      end
      gtg_pkg::ST_MULP: pterm_q <= 35'(mul_p);
      gtg_pkg::ST_MULI: iterm_q <= 41'(mul_p >>> 8);
      gtg_pkg::ST_SUM:  w13_q <= 41'(pterm_q) + iterm_q;
      gtg_pkg::ST_LEFT: begin
        num_q <= base_w + w14_w;
        left_q <= reached_q ? 16'd0 : duty_of(base_w - w14_w, dmax_q);
      end
      gtg_pkg::ST_RIGHT: right_q <= reached_q ? 16'd0 : duty_of(num_q, dmax_q);
      default: ;
    endcase
  end

  always_comb begin
    out_data_o.left_duty       = left_q;
    out_data_o.right_duty      = right_q;
    out_data_o.bearing_to_goal = bear_q;
    out_data_o.goal_reached    = reached_q;
  end

  `ASSERT_IMPL(a_ready_idle, clk_i, rst_ni, in_acc |=> !in_ready_o)
  `ASSERT_NEVER(a_both, clk_i, rst_ni, in_ready_o && out_valid_o)
  `ASSERT_IMPL(a_out_done, clk_i, rst_ni, out_acc |=> in_ready_o)
  `ASSERT_IMPL(a_reach0, clk_i, rst_ni, (out_valid_o && out_data_o.goal_reached) |-> (out_data_o.left_duty == 16'd0))

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking bench for the go-to-goal PI steering controller.
// Predicts bearing, PI turn rate and clamped wheel duties per pose; uses gtg_pkg.
`default_nettype none
module tb_top;

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  gtg_pkg::pose_t in_data_i;
  gtg_pkg::duty_t out_data_o;
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;

  go_to_goal_pi_steering_top dut (.*);

  // controller shadow state
  logic signed [63:0] goal_x_q, goal_y_q;
  logic [15:0] kp_q, ki_q, speed_q, dmax_q, tol_q;
  logic signed [31:0] err_sum_q;

  gtg_pkg::pose_t pose_queue[$];
  gtg_pkg::duty_t duty_queue[$];
  int    errors = 0;
  bit    stim_done = 0;
  bit    hold_sender = 0;
  int    long_stall = 0;

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic signed [63:0] shr_floor(logic signed [63:0] v, int s);
    return v >>> s;
  endfunction

  // atan2 as a 32-bit binary angle by CORDIC vectoring
  function automatic logic [31:0] bearing32(logic signed [63:0] y, logic signed [63:0] x);
    logic [31:0] z;
    logic signed [63:0] t, xs, ys;
    z = '0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 32'h4000_0000;
      end else begin
        x = -y; y = t; z = 32'hC000_0000;
      end
    end
    for (int i = 0; i < 16; i++) begin
      xs = shr_floor(x, i);
      ys = shr_floor(y, i);
      if (y > 0) begin
        x += ys; y -= xs; z += gtg_pkg::ATAN_TAB[i];
      end else begin
        x -= ys; y += xs; z -= gtg_pkg::ATAN_TAB[i];
      end
    end
    return z;
  endfunction

  function automatic logic [15:0] clamp_duty(logic signed [63:0] num);
    logic signed [63:0] d;
    if (num < 0) return '0;
    d = num / 57344;
    return (d > dmax_q) ? dmax_q : d[15:0];
  endfunction

  function automatic gtg_pkg::duty_t steer(gtg_pkg::pose_t p);
    gtg_pkg::duty_t r;
    logic signed [63:0] dx, dy, e, err13, s, w13, base, adx, ady;
    logic [31:0] z;
    logic [15:0] brg, diff;
    dx = goal_x_q - 64'(p.pose_x);
    dy = goal_y_q - 64'(p.pose_y);
    z = bearing32(dy, dx);
    brg = 16'((64'(z) + 64'd32768) >> 16);
    diff = brg - p.pose_heading;
    e = 64'($signed(diff));
    err13 = shr_floor(e * 205887 + 64'sd131072, 18);
    s = 64'(err_sum_q) + err13;
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    err_sum_q = s[31:0];
    w13 = $signed({48'd0, kp_q}) * err13 + shr_floor($signed({48'd0, ki_q}) * s, 8);
    base = $signed({48'd0, speed_q}) * 8192;
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    r.goal_reached = (adx < tol_q) && (ady < tol_q);
    r.left_duty  = r.goal_reached ? 16'd0 : clamp_duty(base - 14 * w13);
    r.right_duty = r.goal_reached ? 16'd0 : clamp_duty(base + 14 * w13);
    r.bearing_to_goal = brg;
    return r;
  endfunction

  // one APB write, setup then access; also updates the shadow copy
  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      gtg_pkg::REG_GOAL_X: goal_x_q = 64'($signed(val[23:0]));
      gtg_pkg::REG_GOAL_Y: goal_y_q = 64'($signed(val[23:0]));
      gtg_pkg::REG_KP:     kp_q = val[15:0];
      gtg_pkg::REG_KI:     ki_q = val[15:0];
      gtg_pkg::REG_SPEED:  speed_q = val[15:0];
      gtg_pkg::REG_DMAX:   dmax_q = val[15:0];
      gtg_pkg::REG_TOL:    tol_q = val[15:0];
      default: ;
    endcase
  endtask

  // wait until every pose is sent and every result is back (sampled mid-cycle)
  task automatic drain;
    while (pose_queue.size() != 0 || in_valid_i || duty_queue.size() != 0)
      @(negedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic gtg_pkg::pose_t rand_pose(int near);
    gtg_pkg::pose_t p;
    if (near != 0) begin
      p.pose_x = goal_x_q[23:0] + 24'($signed($urandom_range(0, 8000)) - 4000);
      p.pose_y = goal_y_q[23:0] + 24'($signed($urandom_range(0, 8000)) - 4000);
    end else begin
      p.pose_x = 24'($urandom);
      p.pose_y = 24'($urandom);
    end
    p.pose_heading = 16'($urandom);
    return p;
  endfunction

  task automatic random_phase(int n);
    repeat (n) pose_queue.push_back(rand_pose($urandom_range(0, 4) == 0));
    drain();
  endtask

  // stimulus
  initial begin
    gtg_pkg::pose_t p;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid_i = 0; in_data_i = '0; out_ready_i = 0;
    goal_x_q = '0; goal_y_q = '0; kp_q = 16'd630; ki_q = 16'd563; speed_q = '0;
    dmax_q = 16'hFFFF; tol_q = 16'd3277; err_sum_q = '0;
    rst_ni = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;

    // directed: reset settings, goal at pose, heading extremes, pi error
    reg_write(gtg_pkg::REG_SPEED, 32'd40000);
    p = '0; pose_queue.push_back(p);
    p.pose_x = 24'sd8388607; p.pose_y = 24'h800000; pose_queue.push_back(p);
    p.pose_x = 24'h800000; p.pose_y = 24'sd8388607; p.pose_heading = 16'hFFFF;
    pose_queue.push_back(p);
    p.pose_x = 24'sd100000; p.pose_y = '0; p.pose_heading = 16'h0000;
    pose_queue.push_back(p); // bearing pi: error of exactly pi
    p.pose_x = '0; p.pose_y = -24'sd100000; p.pose_heading = 16'h8000;
    pose_queue.push_back(p);
    p.pose_x = 24'sd3276; p.pose_y = -24'sd3276; pose_queue.push_back(p);
    p.pose_x = 24'sd3277; p.pose_y = '0; pose_queue.push_back(p); // tolerance edge
    for (int i = 0; i < 8; i++) begin
      p.pose_x = -24'sd5000000; p.pose_y = 24'sd1; p.pose_heading = 16'h0000;
      pose_queue.push_back(p);
    end
    drain();

    reg_write(gtg_pkg::REG_GOAL_X, 32'h7FFFFF);
    reg_write(gtg_pkg::REG_GOAL_Y, 32'h800000);
    reg_write(gtg_pkg::REG_KP, 32'hFFFF);
    reg_write(gtg_pkg::REG_KI, 32'hFFFF);
    reg_write(gtg_pkg::REG_SPEED, 32'hFFFF);
    reg_write(gtg_pkg::REG_DMAX, 32'd30000);
    reg_write(gtg_pkg::REG_TOL, 32'd0);
    // integral built up by repeating one far pose
    p.pose_x = 24'h800000; p.pose_y = 24'sd8388607; p.pose_heading = 16'h4000;
    repeat (6) pose_queue.push_back(p);
    p = '0; pose_queue.push_back(p);
    p.pose_x = 24'sd8388607; p.pose_y = 24'h800000; pose_queue.push_back(p);
    drain();

    // random settings phases
    for (int ph = 0; ph < 8; ph++) begin
      reg_write(gtg_pkg::REG_GOAL_X, $urandom);
      reg_write(gtg_pkg::REG_GOAL_Y, $urandom);
      reg_write(gtg_pkg::REG_KP, (ph == 0) ? 0 : $urandom_range(0, 2000));
      reg_write(gtg_pkg::REG_KI, (ph == 1) ? 0 : $urandom_range(0, 1200));
      reg_write(gtg_pkg::REG_SPEED, $urandom);
      reg_write(gtg_pkg::REG_DMAX, (ph == 2) ? 0 : $urandom);
      reg_write(gtg_pkg::REG_TOL, (ph == 3) ? 16'hFFFF : $urandom_range(0, 20000));
      if (ph == 4) long_stall = 400;
      random_phase(104);
      // sender pause until everything is back
      hold_sender = 1;
      drain();
      hold_sender = 0;
    end
    stim_done = 1;
    drain();
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  // driver
  int gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        duty_queue.push_back(steer(in_data_i));
      end
      if (in_valid_i && !in_ready_o) begin
        // hold
      end else if (gap > 0) begin
        gap <= gap - 1;
        in_valid_i <= 0;
      end else if (pose_queue.size() != 0 && !hold_sender) begin
        in_data_i <= pose_queue.pop_front();
        in_valid_i <= 1;
        gap <= ($urandom_range(0, 3) == 0) ?
               (($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3)) : 0;
      end else begin
        in_valid_i <= 0;
      end
    end
  end

  // monitor and receiver stalls
  int stall = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (duty_queue.size() == 0) begin
          $display("%0t unexpected result %p", $time, out_data_o);
          errors++;
        end else if (duty_queue[0] !== out_data_o) begin
          $display("%0t mismatch expected %p actual %p", $time, duty_queue[0], out_data_o);
          errors++;
          void'(duty_queue.pop_front());
        end else begin
          void'(duty_queue.pop_front());
        end
      end
      if (long_stall > 0) begin
        long_stall <= long_stall - 1;
        out_ready_i <= 0;
      end else if (stall > 0) begin
        stall <= stall - 1;
        out_ready_i <= 0;
      end else begin
        out_ready_i <= 1;
        if ($urandom_range(0, 4) == 0)
          stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
      end
    end
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
`default_nettype wire
